[sv/urd_pkg.sv]
package urd_pkg;

    // Width of the value field at the port, and the width the conversion works on.
    localparam int IN_VALUE_W  = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int MAX_DIGITS  = 32;

    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;
    localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W   = $clog2(MAX_DIGITS);
    localparam int STEP_W  = $clog2(VALUE_WIDTH);

    localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_A    = 7'd65;
    localparam logic [CHAR_W-1:0]  CHAR_F    = 7'd70;
    localparam logic [CHAR_W-1:0]  CHAR_NINE = 7'd57;
    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

    typedef struct packed {
        logic done;
        logic quot_zero;
    } div_status_t;

    function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN)
        begin
            res = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d < DIGIT_TEN)
        begin
            res = CHAR_ZERO + CHAR_W'(d);
        end
        else
        begin
            res = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        end
        return res;
    endfunction

endpackage

[sv/urd_if.sv]
interface urd_in_if;
    import urd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [IN_VALUE_W-1:0]     value;
    logic [RADIX_W-1:0]        radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface urd_out_if;
    import urd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CHAR_W-1:0]     digit_char;
    logic                  last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink   (input valid, input digit_char, input last, output ready);
endinterface

[sv/urd_div.sv]
module urd_div
    import urd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [VALUE_WIDTH-1:0]   dividend,
    input  logic [RADIX_W-1:0]       divisor,
    output logic [VALUE_WIDTH-1:0]   quotient,
    output logic [DIGIT_W-1:0]       remainder,
    output div_status_t              status
);

    logic [VALUE_WIDTH-1:0] quot_reg, quot_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [RADIX_W-1:0]     divisor_reg, divisor_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic [RADIX_W-1:0]     trial;
    logic [RADIX_W-1:0]     diff;
    logic                   fits;

    // Restoring division, one quotient bit per cycle. The dividend shifts out of
    // the top of quot_reg while the quotient bits shift in at the bottom.
    assign trial = {rem_reg, quot_reg[VALUE_WIDTH-1]};
    assign fits  = (trial >= divisor_reg);
    assign diff  = trial - divisor_reg;

    always_comb
    begin
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        step_next    = step_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (start)
        begin
            quot_next    = dividend;
            rem_next     = '0;
            divisor_next = divisor;
            step_next    = STEP_W'(VALUE_WIDTH - 1);
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[VALUE_WIDTH-2:0], fits};
            rem_next  = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        step_reg    <= step_next;
    end

    assign quotient         = quot_reg;
    assign remainder        = rem_reg;
    assign status.done      = done_reg;
    assign status.quot_zero = (quot_reg == '0);

endmodule

[sv/urd_stack.sv]
module urd_stack
#(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_idx,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_idx,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // The read port returns the entry addressed at the previous clock edge.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_idx];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/unsigned_to_radix_digits.sv]
// Channel  | Modport          | Word
// din      | urd_in_if.sink   | value (32, unsigned), radix (5, unsigned)
// dout     | urd_out_if.source| digit_char (7, ASCII), last (1)
//
// Every digit passes through the shared bit-serial divider. After the last division
// the digit buffer read is given time to settle, then one digit leaves per cycle while
// dout is ready; din.ready stays low while an item of 1 to 32 digits is converted.
// din is ready only while no item is in progress; the last digit of one item may
// still wait in the output register when the next word is accepted.
// Reset clears the sequencer, the divider control and the output valid flag.
// A stall on dout holds the digit in the output register and pauses readout.
module unsigned_to_radix_digits
    import urd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    urd_in_if.sink           din,
    urd_out_if.source        dout
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   digit_reg, digit_next;
    logic                last_reg, last_next;
    logic [RADIX_W-1:0]  radix_reg, radix_next;
    logic                fetch_reg, fetch_next;

    logic                    accept;
    logic                    div_start;
    logic [VALUE_WIDTH-1:0]  div_dividend;
    logic [RADIX_W-1:0]      div_divisor;
    logic [VALUE_WIDTH-1:0]  div_quot;
    logic [DIGIT_W-1:0]      div_rem;
    div_status_t             div_status;

    logic                    push;
    logic                    more_digits;
    logic                    load_out;
    logic [CNT_W-1:0]        cnt_m1;
    logic [CNT_W-1:0]        rd_addr;
    logic [DIGIT_W-1:0]      rd_digit;

    assign din.ready = (state_reg == S_IDLE);
    assign accept    = din.valid && din.ready;

    assign push        = (state_reg == S_DIV) && div_status.done;
    assign more_digits = !div_status.quot_zero && (cnt_reg != CNT_W'(MAX_DIGITS - 1));
    assign div_start   = accept || (push && more_digits);
    assign div_dividend = (state_reg == S_IDLE) ? VALUE_WIDTH'(din.value) : div_quot;
    assign div_divisor  = (state_reg == S_IDLE) ? sat_radix(din.radix) : radix_reg;

    assign cnt_m1   = cnt_reg - CNT_W'(1);
    // The buffer data is only trusted once fetch_reg is set, since the final digit is
    // written on the same edge that enters readout, where the registered read is stale.
    assign fetch_next = (state_reg == S_EMIT);
    assign load_out   = (state_reg == S_EMIT) && fetch_reg && (!out_valid_reg || dout.ready);
    // Address the digit that the next count will present.
    assign rd_addr    = cnt_next - CNT_W'(1);

    urd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quot),
        .remainder (div_rem),
        .status    (div_status)
    );

    urd_stack #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_stack (
        .clk     (clk),
        .wr_en   (push),
        .wr_idx  (cnt_reg[IDX_W-1:0]),
        .wr_data (div_rem),
        .rd_idx  (rd_addr[IDX_W-1:0]),
        .rd_data (rd_digit)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !dout.ready;
        digit_next     = digit_reg;
        last_next      = last_reg;
        radix_next     = radix_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = '0;
                    radix_next = sat_radix(din.radix);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (push)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (!more_digits)
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    digit_next     = digit_to_ascii(rd_digit);
                    last_next      = (cnt_reg == CNT_W'(1));
                    cnt_next       = cnt_m1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            fetch_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            fetch_reg     <= fetch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
        last_reg  <= last_next;
        radix_reg <= radix_next;
    end

    assign dout.valid      = out_valid_reg;
    assign dout.digit_char = digit_reg;
    assign dout.last       = last_reg;

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == S_DIV))
        else $error("divider finished outside the division phase");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count exceeds the buffer depth");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !dout.ready) |=>
            (out_valid_reg && $stable(digit_reg) && $stable(last_reg)))
        else $error("output word changed while stalled");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((digit_reg >= CHAR_ZERO && digit_reg <= CHAR_NINE) ||
                           (digit_reg >= CHAR_A && digit_reg <= CHAR_F)))
        else $error("digit character outside 0-9 and A-F");

endmodule

[tb/sv/tb_top.sv]
module tb_top;
    import urd_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_WAIT  = 200;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
    } digit_word_t;

    logic clk;
    logic rst_n;

    urd_in_if  din_ch ();
    urd_out_if dout_ch ();

    unsigned_to_radix_digits dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_ch.sink),
        .dout  (dout_ch.source)
    );

    digit_word_t pending_digits[$];
    int          error_count;
    int          cycle_count;
    bit          idle_on;
    int          hold_left;
    int          sink_gap;

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    function automatic int unsigned base_of(logic [RADIX_W-1:0] r);
        int unsigned b;
        b = r;
        if (b < 2)
        begin
            b = 2;
        end
        else if (b > 16)
        begin
            b = 16;
        end
        return b;
    endfunction

    // Queues the digits of one word, most significant first. Only the
    // MAX_DIGITS least significant digits survive when the count is larger.
    function automatic void queue_digits(logic [IN_VALUE_W-1:0] v, logic [RADIX_W-1:0] r);
        logic [63:0]       rest;
        int unsigned       b;
        int unsigned       d;
        logic [CHAR_W-1:0] chars[64];
        int                n;
        int                keep;
        digit_word_t       w;
        rest = 64'(v) & ({64{1'b1}} >> (64 - VALUE_WIDTH));
        b    = base_of(r);
        n    = 0;
        if (rest == 0)
        begin
            chars[n] = CHAR_ZERO;
            n++;
        end
        while (rest != 0 && n < 64)
        begin
            d = int'(rest % b);
            chars[n] = (d < 10) ? CHAR_ZERO + CHAR_W'(d) : CHAR_A + CHAR_W'(d - 10);
            n++;
            rest = rest / b;
        end
        keep = (n > MAX_DIGITS) ? MAX_DIGITS : n;
        for (int k = 0; k < keep; k++)
        begin
            w.digit_char = chars[keep - 1 - k];
            w.last       = (k == keep - 1);
            pending_digits.push_back(w);
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("tb_top: mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Drives one word at the falling edge, with an optional idle burst before
    // it, and returns once the block has accepted it.
    task automatic send_word(logic [IN_VALUE_W-1:0] v, logic [RADIX_W-1:0] r);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            din_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        din_ch.valid <= 1'b1;
        din_ch.value <= v;
        din_ch.radix <= r;
        do
        begin
            @(posedge clk);
        end
        while (!din_ch.ready);
        queue_digits(v, r);
    endtask

    task automatic test_directed();
        send_word(32'd0, 5'd10);
        send_word(32'd0, 5'd0);
        send_word(32'hFFFF_FFFF, 5'd2);
        send_word(32'hFFFF_FFFF, 5'd16);
        send_word(32'hFFFF_FFFF, 5'd10);
        send_word(32'hFFFF_FFFF, 5'd3);
        send_word(32'h8000_0000, 5'd2);
        send_word(32'd1, 5'd2);
        send_word(32'd5, 5'd0);
        send_word(32'd5, 5'd1);
        send_word(32'hABCD_EF12, 5'd17);
        send_word(32'h1234_5678, 5'd31);
        send_word(32'd15, 5'd16);
        send_word(32'd16, 5'd16);
        send_word(32'd10, 5'd11);
        send_word(32'd9, 5'd10);
        send_word(32'd10, 5'd10);
        send_word(32'd224, 5'd15);
        send_word(32'd4095, 5'd8);
        send_word(32'd2147483647, 5'd7);
        send_word(32'hFEDC_BA98, 5'd13);
        send_word(32'd1, 5'd16);
    endtask

    // The receiver stops for a long stretch while words keep coming, so the
    // block holds a digit in its output register and stops taking input.
    task automatic test_output_hold();
        hold_left = 2500;
        send_word(32'hFFFF_FFFF, 5'd2);
        send_word(32'hDEAD_BEEF, 5'd16);
        send_word(32'd0, 5'd9);
        send_word(32'd123456789, 5'd10);
    endtask

    task automatic test_random(int count, bit with_idle);
        logic [IN_VALUE_W-1:0] v;
        logic [RADIX_W-1:0]    r;
        logic [63:0]           p;
        int unsigned           b;
        int                    steps;
        idle_on = with_idle;
        for (int i = 0; i < count; i++)
        begin
            r = RADIX_W'($urandom_range(0, 31));
            case ($urandom_range(0, 4))
                0: v = $urandom;
                1: v = $urandom_range(0, 255);
                2: v = $urandom >> $urandom_range(0, 31);
                3:
                begin
                    // Values right at a power of the radix, where the digit count steps.
                    b     = base_of(r);
                    p     = 1;
                    steps = $urandom_range(1, 32);
                    for (int k = 0; k < steps && p * b <= 64'hFFFF_FFFF; k++)
                    begin
                        p = p * b;
                    end
                    v = IN_VALUE_W'(p - 64'($urandom_range(0, 1)));
                end
                default: v = $urandom & ~(32'hFFFF_FFFF << $urandom_range(1, 16));
            endcase
            send_word(v, r);
        end
    endtask

    initial
    begin
        int drain;
        rst_n         = 1'b0;
        din_ch.valid  = 1'b0;
        din_ch.value  = '0;
        din_ch.radix  = '0;
        error_count   = 0;
        idle_on       = 1'b1;
        hold_left     = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_output_hold();
        test_random(300, 1'b1);
        test_random(180, 1'b0);

        @(negedge clk);
        din_ch.valid <= 1'b0;
        while (pending_digits.size() != 0)
        begin
            @(posedge clk);
        end
        drain = DRAIN_WAIT;
        repeat (drain) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial
    begin
        dout_ch.ready = 1'b0;
        sink_gap      = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                dout_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (sink_gap > 0)
            begin
                dout_ch.ready <= 1'b0;
                sink_gap--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                dout_ch.ready <= 1'b0;
                sink_gap = $urandom_range(1, 10) - 1;
            end
            else
            begin
                dout_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : digit_check
        digit_word_t want;
        if (rst_n && dout_ch.valid && dout_ch.ready)
        begin
            if (pending_digits.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word char=%0d last=%0b",
                                          dout_ch.digit_char, dout_ch.last));
            end
            else
            begin
                want = pending_digits.pop_front();
                if (dout_ch.digit_char !== want.digit_char)
                begin
                    report_mismatch($sformatf("digit_char %0d, expected %0d",
                                              dout_ch.digit_char, want.digit_char));
                end
                if (dout_ch.last !== want.last)
                begin
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              dout_ch.last, want.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
    end

endmodule

[sim.f]
sv/urd_pkg.sv
sv/urd_if.sv
sv/urd_div.sv
sv/urd_stack.sv
sv/unsigned_to_radix_digits.sv
tb/sv/tb_top.sv
